[sv/dsl_pkg.sv]
// Shared constants, tables and helpers for the 2D direction slerp core.
package dsl_pkg;

    localparam int VEC_W   = 16;
    localparam int LAM_W   = 17;
    localparam int CFG_W   = 16;
    localparam int STAT_W  = 2;
    localparam int CW      = 34;   // CORDIC datapath width (Q2.30 plus gain headroom)
    localparam int SQW     = 64;   // square-root radicand width
    localparam int SQ_STEPS = 32;  // one result bit per step

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_COLIN = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO  = 2'd2;

    localparam logic [CFG_W-1:0] COLIN_LIMIT_RST = 16'd1074;
    localparam logic [LAM_W-1:0] LAM_ONE         = 17'd65536;

    localparam logic signed [31:0] DOT_ONE  = 32'sd1073741824;
    localparam logic signed [31:0] DOT_MONE = -32'sd1073741824;
    localparam logic [31:0] Q30_PI      = 32'd3373259426;
    localparam logic [31:0] Q30_HALF_PI = 32'd1686629713;

    // atan(2^-i) in Q2.30
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686, 32'd33543515, 32'd16775850, 32'd8388437,
        32'd4194282, 32'd2097149, 32'd1048575, 32'd524287,
        32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047,
        32'd1023, 32'd511, 32'd255, 32'd127,
        32'd63, 32'd31, 32'd15, 32'd8,
        32'd4, 32'd2, 32'd1, 32'd0
    };

    // sine is symmetric about pi/2
    function automatic logic [31:0] fold_ang(input logic [31:0] a);
        logic [31:0] r;
        if (a > Q30_HALF_PI)
        begin
            r = Q30_PI - a;
        end
        else
        begin
            r = a;
        end
        return r;
    endfunction

endpackage

[sv/dsl_if.sv]
// Handshake channels for the slerp core: input pair and interpolated result.
interface dsl_item_if;
    import dsl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] a_x;
    logic signed [VEC_W-1:0] a_y;
    logic signed [VEC_W-1:0] b_x;
    logic signed [VEC_W-1:0] b_y;
    logic [LAM_W-1:0]        lambda;

    modport source (output valid, a_x, a_y, b_x, b_y, lambda, input ready);
    modport sink (input valid, a_x, a_y, b_x, b_y, lambda, output ready);
endinterface

interface dsl_result_if;
    import dsl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic [STAT_W-1:0]       status;

    modport source (output valid, out_x, out_y, status, input ready);
    modport sink (input valid, out_x, out_y, status, output ready);
endinterface

[sv/direction_slerp_2d_core.sv]
// One beat per cycle unless the result stalls; every stage is a register, mostly in the cell chains
// (two 32-step square roots, vectoring and sine CORDICs, restoring divider).
// A stalled result freezes the whole chain; ready is low only while the result waits.
// Reset (rst_n low, async) empties every stage and loads colinear_limit with 1074.
// The whole pipeline advances together, so no item is dropped or duplicated.
module direction_slerp_2d_core #(
    parameter int VEC_FRAC_BITS = 14,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    dsl_item_if.sink                    item,
    dsl_result_if.source                result,
    input  logic                        cfg_we,
    input  logic [dsl_pkg::CFG_W-1:0]   cfg_wdata
);
    import dsl_pkg::*;

    localparam int QW    = VEC_FRAC_BITS + 2;
    localparam int DW    = 33;
    localparam int NW    = DW + QW;
    localparam int RSH   = (2 * VEC_FRAC_BITS >= 30) ? 2 * VEC_FRAC_BITS - 30 : 0;
    localparam int LSH   = (2 * VEC_FRAC_BITS < 30) ? 30 - 2 * VEC_FRAC_BITS : 0;
    localparam int ZSH_L = (VEC_FRAC_BITS < 17) ? 17 - VEC_FRAC_BITS : 0;
    localparam int ZSH_R = (VEC_FRAC_BITS >= 17) ? VEC_FRAC_BITS - 17 : 0;

    typedef struct packed {
        logic signed [VEC_W-1:0] ax;
        logic signed [VEC_W-1:0] ay;
        logic signed [VEC_W-1:0] bx;
        logic signed [VEC_W-1:0] by;
        logic [LAM_W-1:0]        lam;
    } base_t;

    typedef struct packed {
        base_t             b;
        logic signed [31:0] dot;
    } sd_root_t;

    typedef struct packed {
        base_t              b;
        logic signed [31:0] dot;
        logic [31:0]        s;
    } sd_vec_t;

    typedef struct packed {
        base_t       b;
        logic [31:0] s;
    } sd_sin_t;

    typedef struct packed {
        logic signed [31:0]   sx;
        logic signed [31:0]   sy;
        logic signed [CW-1:0] ss;
        logic                 colin;
    } sd_mag_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              neg_x;
        logic              neg_y;
    } sd_div_t;

    localparam int RT_W  = $bits(sd_root_t);
    localparam int VC_W  = $bits(sd_vec_t);
    localparam int SN_W  = $bits(sd_sin_t);
    localparam int MG_W  = $bits(sd_mag_t);
    localparam int DV_W  = $bits(sd_div_t);

    logic adv;
    logic [CFG_W-1:0] limit_reg;

    // front stages
    logic               s0_vld_reg, s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    base_t              s0_reg, s1_reg, s2_reg, s3_reg, s4_reg;
    logic signed [31:0] s1_px_reg, s1_py_reg;
    logic signed [31:0] s2_dot_reg, s3_dot_reg, s4_dot_reg;
    logic signed [31:0] dot_next;
    logic [63:0]        s3_dsq_reg, s4_rad_reg;
    base_t              s0_next;

    // middle stages
    logic               t_vld_reg, l_vld_reg, f_vld_reg;
    base_t              t_b_reg, l_b_reg, f_b_reg;
    logic [31:0]        t_s_reg, l_s_reg, f_s_reg;
    logic [31:0]        t_theta_reg, l_theta_reg;
    logic [31:0]        theta_next, l_lb_reg;
    logic [31:0]        f_za_reg, f_zb_reg, f_zs_reg;
    logic [48:0]        lb_prod;

    logic                 m_vld_reg, a_vld_reg, q_vld_reg, r_vld_reg, z_vld_reg;
    logic signed [49:0]   m_pax_reg, m_pbx_reg, m_pay_reg, m_pby_reg;
    logic signed [CW-1:0] m_ss_reg, a_ss_reg, q_ss_reg, r_ss_reg;
    logic                 m_colin_reg, a_colin_reg, q_colin_reg, r_colin_reg;
    logic signed [31:0]   a_sx_reg, a_sy_reg, q_sx_reg, q_sy_reg, r_sx_reg, r_sy_reg;
    logic [63:0]          q_sxsq_reg, q_sysq_reg, r_v_reg;
    logic signed [50:0]   tx, ty;

    logic [1:0][NW-1:0] z_num_reg;
    logic [DW-1:0]      z_den_reg;
    sd_div_t            z_side_reg, z_side_next;
    logic [31:0]        mag, abs_x, abs_y;
    logic [63:0]        lhs, rhs;

    logic                    res_vld_reg;
    logic signed [VEC_W-1:0] res_x_reg, res_y_reg, res_x_next, res_y_next;
    logic [STAT_W-1:0]       res_st_reg;

    assign adv        = !res_vld_reg || result.ready;
    assign item.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= COLIN_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // ---------------- front: dot product and radicand ----------------
    always_comb
    begin
        logic signed [63:0] dsum, dsh;
        s0_next.ax  = item.a_x;
        s0_next.ay  = item.a_y;
        s0_next.bx  = item.b_x;
        s0_next.by  = item.b_y;
        s0_next.lam = (item.lambda > LAM_ONE) ? LAM_ONE : item.lambda;
        dsum = 64'(s1_px_reg) + 64'(s1_py_reg);
        dsh  = (dsum >>> RSH) <<< LSH;
        if (dsh > 64'(DOT_ONE))
        begin
            dot_next = DOT_ONE;
        end
        else if (dsh < 64'(DOT_MONE))
        begin
            dot_next = DOT_MONE;
        end
        else
        begin
            dot_next = dsh[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= item.valid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg     <= s0_next;
            s1_reg     <= s0_reg;
            s1_px_reg  <= s0_reg.ax * s0_reg.bx;
            s1_py_reg  <= s0_reg.ay * s0_reg.by;
            s2_reg     <= s1_reg;
            s2_dot_reg <= dot_next;
            s3_reg     <= s2_reg;
            s3_dot_reg <= s2_dot_reg;
            s3_dsq_reg <= 64'(64'(s2_dot_reg) * 64'(s2_dot_reg));
            s4_reg     <= s3_reg;
            s4_dot_reg <= s3_dot_reg;
            s4_rad_reg <= (64'(1) << 60) - s3_dsq_reg;
        end
    end

    // ---------------- sin(theta) = sqrt(1 - dot^2) ----------------
    logic [SQ_STEPS:0]               r1_vld;
    logic [SQ_STEPS:0][SQW-1:0]      r1_v, r1_r;
    logic [SQ_STEPS:0][RT_W-1:0]     r1_side;
    sd_root_t                        r1_in, r1_out;

    assign r1_in.b   = s4_reg;
    assign r1_in.dot = s4_dot_reg;
    assign r1_vld[0]  = s4_vld_reg;
    assign r1_v[0]    = s4_rad_reg;
    assign r1_r[0]    = '0;
    assign r1_side[0] = r1_in;

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_root1
        dsl_sqrt_cell #(.W(SQW), .P(SQ_STEPS - 1 - i), .SIDE_W(RT_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv),
            .vld_in(r1_vld[i]), .v_in(r1_v[i]), .r_in(r1_r[i]), .side_in(r1_side[i]),
            .vld_out(r1_vld[i+1]), .v_out(r1_v[i+1]), .r_out(r1_r[i+1]),
            .side_out(r1_side[i+1])
        );
    end

    assign r1_out = sd_root_t'(r1_side[SQ_STEPS]);

    // ---------------- theta by vectoring CORDIC ----------------
    logic [CORDIC_STAGES:0]             vc_vld;
    logic [CORDIC_STAGES:0][0:0][CW-1:0] vc_x, vc_y, vc_z;
    logic [CORDIC_STAGES:0][VC_W-1:0]   vc_side;
    sd_vec_t                            vc_in, vc_out;

    assign vc_in.b   = r1_out.b;
    assign vc_in.dot = r1_out.dot;
    assign vc_in.s   = r1_r[SQ_STEPS][31:0];
    assign vc_vld[0]  = r1_vld[SQ_STEPS];
    assign vc_x[0][0] = r1_out.dot[31] ? CW'(-r1_out.dot) : CW'(r1_out.dot);
    assign vc_y[0][0] = CW'(r1_r[SQ_STEPS][31:0]);
    assign vc_z[0][0] = '0;
    assign vc_side[0] = vc_in;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_vec
        dsl_cordic_cell #(.LANES(1), .W(CW), .K(i), .VECTORING(1'b1), .SIDE_W(VC_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv),
            .vld_in(vc_vld[i]), .x_in(vc_x[i]), .y_in(vc_y[i]), .z_in(vc_z[i]),
            .side_in(vc_side[i]),
            .vld_out(vc_vld[i+1]), .x_out(vc_x[i+1]), .y_out(vc_y[i+1]), .z_out(vc_z[i+1]),
            .side_out(vc_side[i+1])
        );
    end

    assign vc_out = sd_vec_t'(vc_side[CORDIC_STAGES]);

    always_comb
    begin
        logic [31:0] zt;
        zt = vc_z[CORDIC_STAGES][0][31:0];
        if (vc_out.dot == DOT_ONE)
        begin
            theta_next = '0;
        end
        else if (vc_out.dot == DOT_MONE)
        begin
            theta_next = Q30_PI;
        end
        else if (vc_out.dot[31])
        begin
            theta_next = Q30_PI - zt;
        end
        else
        begin
            theta_next = zt;
        end
    end

    assign lb_prod = 49'(t_theta_reg) * 49'(t_b_reg.lam);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_vld_reg <= 1'b0;
            l_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            t_vld_reg <= vc_vld[CORDIC_STAGES];
            l_vld_reg <= t_vld_reg;
            f_vld_reg <= l_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_b_reg     <= vc_out.b;
            t_s_reg     <= vc_out.s;
            t_theta_reg <= theta_next;
            l_b_reg     <= t_b_reg;
            l_s_reg     <= t_s_reg;
            l_theta_reg <= t_theta_reg;
            l_lb_reg    <= lb_prod[47:16];
            f_b_reg     <= l_b_reg;
            f_s_reg     <= l_s_reg;
            f_za_reg    <= fold_ang(l_theta_reg - l_lb_reg);
            f_zb_reg    <= fold_ang(l_lb_reg);
            f_zs_reg    <= fold_ang(l_theta_reg);
        end
    end

    // ---------------- three sines: lanes (1-lambda)theta, lambda theta, theta ----------------
    logic [CORDIC_STAGES:0]               sn_vld;
    logic [CORDIC_STAGES:0][2:0][CW-1:0]  sn_x, sn_y, sn_z;
    logic [CORDIC_STAGES:0][SN_W-1:0]     sn_side;
    sd_sin_t                              sn_in, sn_out;

    assign sn_in.b   = f_b_reg;
    assign sn_in.s   = f_s_reg;
    assign sn_vld[0]  = f_vld_reg;
    assign sn_x[0]    = {3{CW'(DOT_ONE)}};
    assign sn_y[0]    = '0;
    assign sn_z[0]    = {CW'(f_zs_reg), CW'(f_zb_reg), CW'(f_za_reg)};
    assign sn_side[0] = sn_in;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_sin
        dsl_cordic_cell #(.LANES(3), .W(CW), .K(i), .VECTORING(1'b0), .SIDE_W(SN_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv),
            .vld_in(sn_vld[i]), .x_in(sn_x[i]), .y_in(sn_y[i]), .z_in(sn_z[i]),
            .side_in(sn_side[i]),
            .vld_out(sn_vld[i+1]), .x_out(sn_x[i+1]), .y_out(sn_y[i+1]), .z_out(sn_z[i+1]),
            .side_out(sn_side[i+1])
        );
    end

    assign sn_out = sd_sin_t'(sn_side[CORDIC_STAGES]);

    // ---------------- weighted sum and its squared length ----------------
    logic signed [CW-1:0] sa, sb, ss;
    assign sa = $signed(sn_y[CORDIC_STAGES][0]);
    assign sb = $signed(sn_y[CORDIC_STAGES][1]);
    assign ss = $signed(sn_y[CORDIC_STAGES][2]);

    assign tx = 51'(m_pax_reg) + 51'(m_pbx_reg);
    assign ty = 51'(m_pay_reg) + 51'(m_pby_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
            a_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_vld_reg <= sn_vld[CORDIC_STAGES];
            a_vld_reg <= m_vld_reg;
            q_vld_reg <= a_vld_reg;
            r_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_pax_reg   <= sa * sn_out.b.ax;
            m_pbx_reg   <= sb * sn_out.b.bx;
            m_pay_reg   <= sa * sn_out.b.ay;
            m_pby_reg   <= sb * sn_out.b.by;
            m_ss_reg    <= ss;
            m_colin_reg <= (sn_out.s < 32'(limit_reg)) || (ss <= 0);
            a_sx_reg    <= tx[48:17];
            a_sy_reg    <= ty[48:17];
            a_ss_reg    <= m_ss_reg;
            a_colin_reg <= m_colin_reg;
            q_sx_reg    <= a_sx_reg;
            q_sy_reg    <= a_sy_reg;
            q_sxsq_reg  <= 64'(64'(a_sx_reg) * 64'(a_sx_reg));
            q_sysq_reg  <= 64'(64'(a_sy_reg) * 64'(a_sy_reg));
            q_ss_reg    <= a_ss_reg;
            q_colin_reg <= a_colin_reg;
            r_sx_reg    <= q_sx_reg;
            r_sy_reg    <= q_sy_reg;
            r_v_reg     <= q_sxsq_reg + q_sysq_reg;
            r_ss_reg    <= q_ss_reg;
            r_colin_reg <= q_colin_reg;
        end
    end

    // ---------------- magnitude ----------------
    logic [SQ_STEPS:0]           r2_vld;
    logic [SQ_STEPS:0][SQW-1:0]  r2_v, r2_r;
    logic [SQ_STEPS:0][MG_W-1:0] r2_side;
    sd_mag_t                     r2_in, r2_out;

    assign r2_in.sx    = r_sx_reg;
    assign r2_in.sy    = r_sy_reg;
    assign r2_in.ss    = r_ss_reg;
    assign r2_in.colin = r_colin_reg;
    assign r2_vld[0]  = r_vld_reg;
    assign r2_v[0]    = r_v_reg;
    assign r2_r[0]    = '0;
    assign r2_side[0] = r2_in;

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_root2
        dsl_sqrt_cell #(.W(SQW), .P(SQ_STEPS - 1 - i), .SIDE_W(MG_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv),
            .vld_in(r2_vld[i]), .v_in(r2_v[i]), .r_in(r2_r[i]), .side_in(r2_side[i]),
            .vld_out(r2_vld[i+1]), .v_out(r2_v[i+1]), .r_out(r2_r[i+1]),
            .side_out(r2_side[i+1])
        );
    end

    assign r2_out = sd_mag_t'(r2_side[SQ_STEPS]);

    always_comb
    begin
        mag   = r2_r[SQ_STEPS][31:0];
        abs_x = r2_out.sx[31] ? 32'(-r2_out.sx) : 32'(r2_out.sx);
        abs_y = r2_out.sy[31] ? 32'(-r2_out.sy) : 32'(r2_out.sy);
        lhs   = (64'(mag) * 64'd1000) << ZSH_L;
        rhs   = 64'(r2_out.ss) << ZSH_R;
        z_side_next.neg_x = r2_out.sx[31];
        z_side_next.neg_y = r2_out.sy[31];
        if (r2_out.colin)
        begin
            z_side_next.status = ST_COLIN;
        end
        else if (mag == '0 || lhs < rhs)
        begin
            z_side_next.status = ST_ZERO;
        end
        else
        begin
            z_side_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            z_vld_reg <= r2_vld[SQ_STEPS];
        end
    end

    // rounding: (2*m*2^F + mag) / (2*mag)
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_num_reg[0] <= (NW'(abs_x) << (VEC_FRAC_BITS + 1)) + NW'(mag);
            z_num_reg[1] <= (NW'(abs_y) << (VEC_FRAC_BITS + 1)) + NW'(mag);
            z_den_reg    <= {mag, 1'b0};
            z_side_reg   <= z_side_next;
        end
    end

    // ---------------- normalize by division ----------------
    logic [QW:0]                 dv_vld;
    logic [QW:0][1:0][NW-1:0]    dv_rem;
    logic [QW:0][1:0][QW-1:0]    dv_q;
    logic [QW:0][DW-1:0]         dv_den;
    logic [QW:0][DV_W-1:0]       dv_side;
    sd_div_t                     dv_out;

    assign dv_vld[0]  = z_vld_reg;
    assign dv_rem[0]  = z_num_reg;
    assign dv_q[0]    = '0;
    assign dv_den[0]  = z_den_reg;
    assign dv_side[0] = z_side_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        dsl_div_cell #(.LANES(2), .NW(NW), .DW(DW), .QW(QW), .J(QW - 1 - i),
                       .SIDE_W(DV_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv),
            .vld_in(dv_vld[i]), .rem_in(dv_rem[i]), .q_in(dv_q[i]), .den_in(dv_den[i]),
            .side_in(dv_side[i]),
            .vld_out(dv_vld[i+1]), .rem_out(dv_rem[i+1]), .q_out(dv_q[i+1]),
            .den_out(dv_den[i+1]), .side_out(dv_side[i+1])
        );
    end

    assign dv_out = sd_div_t'(dv_side[QW]);

    always_comb
    begin
        logic [63:0] qx, qy;
        qx = 64'(dv_q[QW][0]);
        qy = 64'(dv_q[QW][1]);
        if (dv_out.neg_x)
        begin
            res_x_next = (qx > 64'd32768) ? 16'sh8000 : 16'(-qx);
        end
        else
        begin
            res_x_next = (qx > 64'd32767) ? 16'sh7FFF : 16'(qx);
        end
        if (dv_out.neg_y)
        begin
            res_y_next = (qy > 64'd32768) ? 16'sh8000 : 16'(-qy);
        end
        else
        begin
            res_y_next = (qy > 64'd32767) ? 16'sh7FFF : 16'(qy);
        end
        if (dv_out.status != ST_OK)
        begin
            res_x_next = '0;
            res_y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_vld_reg <= dv_vld[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_x_reg  <= res_x_next;
            res_y_reg  <= res_y_next;
            res_st_reg <= dv_out.status;
        end
    end

    assign result.valid  = res_vld_reg;
    assign result.out_x  = res_x_reg;
    assign result.out_y  = res_y_reg;
    assign result.status = res_st_reg;

`ifndef SYNTHESIS
    a_ready_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready == (!result.valid || result.ready))
        else $error("input ready does not follow output stall");

    a_error_zeroes_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_OK) |-> (result.out_x == '0 && result.out_y == '0))
        else $error("error beat carries a nonzero vector");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.status == ST_OK || result.status == ST_COLIN
                          || result.status == ST_ZERO))
        else $error("undefined status code");

    a_stall_freezes_entry: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s0_vld_reg) && $stable(res_vld_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule

[sv/dsl_cordic_cell.sv]
// One CORDIC micro-rotation cell, several independent lanes, rotation or vectoring.
module dsl_cordic_cell #(
    parameter int LANES     = 1,
    parameter int W         = 34,
    parameter int K         = 0,
    parameter bit VECTORING = 1'b0,
    parameter int SIDE_W    = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       vld_in,
    input  logic [LANES-1:0][W-1:0]    x_in,
    input  logic [LANES-1:0][W-1:0]    y_in,
    input  logic [LANES-1:0][W-1:0]    z_in,
    input  logic [SIDE_W-1:0]          side_in,
    output logic                       vld_out,
    output logic [LANES-1:0][W-1:0]    x_out,
    output logic [LANES-1:0][W-1:0]    y_out,
    output logic [LANES-1:0][W-1:0]    z_out,
    output logic [SIDE_W-1:0]          side_out
);
    import dsl_pkg::*;

    localparam logic signed [W-1:0] ANG = W'(ATAN_TAB[K]);

    logic                    vld_reg;
    logic [LANES-1:0][W-1:0] x_reg, y_reg, z_reg;
    logic [LANES-1:0][W-1:0] x_next, y_next, z_next;
    logic [SIDE_W-1:0]       side_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic signed [W-1:0] xs, ys, zs, dx, dy;
            logic                neg;
            xs = $signed(x_in[l]);
            ys = $signed(y_in[l]);
            zs = $signed(z_in[l]);
            dx = ys >>> K;
            dy = xs >>> K;
            // vectoring drives y to zero, rotation drives z to zero
            neg = VECTORING ? ~ys[W-1] : zs[W-1];
            if (neg)
            begin
                x_next[l] = xs + dx;
                y_next[l] = ys - dy;
                z_next[l] = zs + ANG;
            end
            else
            begin
                x_next[l] = xs - dx;
                y_next[l] = ys + dy;
                z_next[l] = zs - ANG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;

endmodule

[sv/dsl_sqrt_cell.sv]
// One step of a digit-by-digit integer square root, one result bit per cell.
module dsl_sqrt_cell #(
    parameter int W      = 64,
    parameter int P      = 0,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  logic [W-1:0]      v_in,
    input  logic [W-1:0]      r_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vld_out,
    output logic [W-1:0]      v_out,
    output logic [W-1:0]      r_out,
    output logic [SIDE_W-1:0] side_out
);
    localparam logic [W-1:0] BITV = W'(1) << (2 * P);

    logic              vld_reg;
    logic [W-1:0]      v_reg, r_reg, v_next, r_next, trial;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        trial = r_in + BITV;
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + BITV;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg    <= v_next;
            r_reg    <= r_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign v_out    = v_reg;
    assign r_out    = r_reg;
    assign side_out = side_reg;

endmodule

[sv/dsl_div_cell.sv]
// One restoring-division step, one quotient bit per cell, shared divisor across lanes.
module dsl_div_cell #(
    parameter int LANES  = 2,
    parameter int NW     = 49,
    parameter int DW     = 33,
    parameter int QW     = 16,
    parameter int J      = 0,
    parameter int SIDE_W = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     vld_in,
    input  logic [LANES-1:0][NW-1:0] rem_in,
    input  logic [LANES-1:0][QW-1:0] q_in,
    input  logic [DW-1:0]            den_in,
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     vld_out,
    output logic [LANES-1:0][NW-1:0] rem_out,
    output logic [LANES-1:0][QW-1:0] q_out,
    output logic [DW-1:0]            den_out,
    output logic [SIDE_W-1:0]        side_out
);
    logic                     vld_reg;
    logic [LANES-1:0][NW-1:0] rem_reg, rem_next;
    logic [LANES-1:0][QW-1:0] q_reg, q_next;
    logic [DW-1:0]            den_reg;
    logic [SIDE_W-1:0]        side_reg;
    logic [NW-1:0]            dsh;

    always_comb
    begin
        dsh = NW'(den_in) << J;
        for (int l = 0; l < LANES; l++)
        begin
            if (rem_in[l] >= dsh)
            begin
                rem_next[l] = rem_in[l] - dsh;
                q_next[l]   = q_in[l] | (QW'(1) << J);
            end
            else
            begin
                rem_next[l] = rem_in[l];
                q_next[l]   = q_in[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            den_reg  <= den_in;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
    assign den_out  = den_reg;
    assign side_out = side_reg;

endmodule
